/* rtl/ohm_pkg.sv */
// Package for the online higher-moment accumulator: item types, sequencer codes, saturation helpers.
package ohm_pkg;

    localparam int COUNT_BITS_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] MEAN_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] MEAN_MIN = -64'sd140737488355328;

    typedef struct packed {
        logic [31:0] sample;
        logic        restart;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        count;
        logic signed [47:0] mean;
        logic [62:0]        second_sum;
        logic signed [63:0] third_sum;
        logic [62:0]        fourth_sum;
        logic               saturated;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_DONE
    } t_state;

    // Micro-program, executed in order; products take the multiplier, the rest the adder.
    typedef enum logic [4:0] {
        OP_DELTA, OP_MEAN, OP_P, OP_T1, OP_E2, OP_NN, OP_POLY,
        OP_A4A, OP_A4B, OP_M4A, OP_B4A, OP_B4B, OP_M4B, OP_C4A, OP_C4B, OP_M4C,
        OP_A3A, OP_A3B, OP_M3A, OP_B3A, OP_B3B, OP_M3B, OP_M2
    } t_op;

    typedef struct packed {
        logic signed [63:0] value;
        logic               ovf;
    } t_sat;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    // Signed 64-bit result from sign and 128-bit magnitude, saturating.
    function automatic t_sat from_mag(input logic neg, input logic [127:0] m);
        t_sat r;
        if (neg) begin
            if (m[127:64] != 64'd0 || m[63:0] > 64'h8000_0000_0000_0000) begin
                r.value = S64_MIN;
                r.ovf   = 1'b1;
            end else begin
                r.value = 64'sd0 - $signed(m[63:0]);
                r.ovf   = 1'b0;
            end
        end else begin
            if (m[127:64] != 64'd0 || m[63]) begin
                r.value = S64_MAX;
                r.ovf   = 1'b1;
            end else begin
                r.value = $signed(m[63:0]);
                r.ovf   = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic t_sat sat_addsub(input logic signed [63:0] a,
                                        input logic signed [63:0] b,
                                        input logic sub);
        t_sat r;
        logic signed [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            r.value = s[64] ? S64_MIN : S64_MAX;
            r.ovf   = 1'b1;
        end else begin
            r.value = s[63:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage

/* rtl/online_higher_moments.sv */
// Online higher-moment accumulator: running count, mean and M2/M3/M4 sums on shared units.
//
// Usage: one input channel (i_in_valid / o_in_stall, payload i_in_data) carries a
// Q16.16 sample and a restart bit; one output channel (o_out_valid / i_out_stall,
// payload o_out_data) returns count, Q16.32 mean, the three central moment sums
// and a sticky saturation flag after every sample.
// One sample is worked at a time; o_in_stall stays high until its result has been
// moved into the output register. Between input transfer and o_out_valid each
// sample passes the bit-serial restoring divider for delta/n, 14 products on one
// 32x32 multiplier (each four partial products and a shift/saturate step),
// 9 saturating adds and the load of the result register.
// The result register frees the input side: a new sample may be taken while the
// last result waits, and the sequencer only holds at its final step while the
// receiver stalls with a result still pending.
// Synchronous reset clears count, mean, sums, the flag and all handshake state.
module online_higher_moments
    import ohm_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [63:0] SMASK = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    t_state r_state, n_state;
    t_op    r_pc, n_pc;

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] r_n, n_n;
    logic signed [47:0]    r_mean, n_mean;
    logic signed [63:0]    r_m2, n_m2, r_m3, n_m3, r_m4, n_m4;
    logic                  r_flag, n_flag;
    logic signed [63:0]    r_x, n_x, r_delta, n_delta, r_e, n_e, r_t1, n_t1;
    logic signed [63:0]    r_e2, n_e2, r_poly, n_poly, r_tmp, n_tmp, r_acc, n_acc;
    logic [63:0]           r_quo, n_quo;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [5:0]            r_dcnt, n_dcnt;
    logic [2:0]            r_mcnt, n_mcnt;
    logic [127:0]          r_prod, n_prod;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic in_xfer, out_free, op_mul, div_last, mul_last;
    logic signed [63:0] mul_a, mul_b, add_a, add_b, n64;
    logic [5:0]  mul_sh;
    logic        add_sub;
    logic [63:0] ma, mb, raw, xs;
    logic [31:0] ha, hb;
    logic [127:0] pp, prod_sh;
    logic [COUNT_BITS:0] rem_sh;
    t_sat mul_res, add_res, e_res;
    logic [COUNT_BITS-1:0] cnt_eff;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign n64      = $signed(64'(r_n));
    assign div_last = (r_dcnt == 6'd63);
    assign mul_last = (r_mcnt == 3'd4);

    // operand selection for the shared multiplier and adder
    always_comb begin
        op_mul  = 1'b1;
        mul_a   = r_tmp;
        mul_b   = r_tmp;
        mul_sh  = 6'd0;
        add_a   = r_acc;
        add_b   = r_tmp;
        add_sub = 1'b0;
        unique case (r_pc)
            OP_DELTA: begin op_mul = 1'b0; add_a = r_x; add_b = 64'(r_mean); add_sub = 1'b1; end
            OP_MEAN:  begin op_mul = 1'b0; add_a = 64'(r_mean); add_b = r_e; end
            OP_P:     begin mul_a = r_delta; mul_b = r_e; mul_sh = 6'd48; end
            OP_T1:    begin mul_a = r_t1; mul_b = n64 - 64'sd1; end
            OP_E2:    begin mul_a = r_e; mul_b = r_e; mul_sh = 6'd32; end
            OP_NN:    begin mul_a = n64; mul_b = n64 - 64'sd3; end
            OP_POLY:  begin op_mul = 1'b0; add_a = r_poly; add_b = 64'sd3; end
            OP_A4A:   begin mul_a = r_t1; mul_b = r_e2; mul_sh = 6'd32; end
            OP_A4B:   begin mul_b = r_poly; end
            OP_M4A:   begin op_mul = 1'b0; add_a = r_m4; end
            OP_B4A:   begin mul_a = r_e2; mul_b = r_m2; mul_sh = 6'd32; end
            OP_B4B:   begin mul_b = 64'sd6; end
            OP_M4B:   begin op_mul = 1'b0; end
            OP_C4A:   begin mul_a = r_e; mul_b = r_m3; mul_sh = 6'd32; end
            OP_C4B:   begin mul_b = 64'sd4; end
            OP_M4C:   begin op_mul = 1'b0; add_sub = 1'b1; end
            OP_A3A:   begin mul_a = r_t1; mul_b = r_e; mul_sh = 6'd32; end
            OP_A3B:   begin mul_b = n64 - 64'sd2; end
            OP_M3A:   begin op_mul = 1'b0; add_a = r_m3; end
            OP_B3A:   begin mul_a = r_e; mul_b = r_m2; mul_sh = 6'd32; end
            OP_B3B:   begin mul_b = 64'sd3; end
            OP_M3B:   begin op_mul = 1'b0; add_sub = 1'b1; end
            OP_M2:    begin op_mul = 1'b0; add_a = r_m2; add_b = r_t1; end
            default:  begin op_mul = 1'b0; end
        endcase
    end

    // shared units: 32x32 partial product per cycle, saturating adder, divider step
    always_comb begin
        ma      = mag64(mul_a);
        mb      = mag64(mul_b);
        ha      = r_mcnt[0] ? ma[63:32] : ma[31:0];
        hb      = r_mcnt[1] ? mb[63:32] : mb[31:0];
        pp      = 128'(64'(ha) * 64'(hb)) << {(2'(r_mcnt[0]) + 2'(r_mcnt[1])), 5'd0};
        prod_sh = r_prod >> mul_sh;
        mul_res = from_mag(mul_a[63] ^ mul_b[63], prod_sh);
        add_res = sat_addsub(add_a, add_b, add_sub);
        rem_sh  = {r_rem, r_quo[63]};
        e_res   = from_mag(r_delta[63], {64'd0, r_quo[62:0], (rem_sh >= {1'b0, r_n})});
        raw     = {32'd0, i_in_data.sample} & SMASK;
        xs      = raw[SAMPLE_BITS-1] ? (raw | ~SMASK) : raw;
        cnt_eff = i_in_data.restart ? '0 : r_count;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_RUN;
                    n_pc    = OP_DELTA;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    n_state = ST_RUN;
                    n_pc    = OP_MEAN;
                end
            end
            ST_RUN: begin
                if (!op_mul || mul_last) begin
                    if (r_pc == OP_DELTA) begin
                        n_state = ST_DIV;
                    end else if (r_pc == OP_M2) begin
                        n_state = ST_DONE;
                    end else begin
                        n_pc = t_op'(r_pc + 5'd1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    // datapath
    always_comb begin
        n_count = r_count;  n_n = r_n;   n_mean = r_mean;
        n_m2 = r_m2;  n_m3 = r_m3;  n_m4 = r_m4;  n_flag = r_flag;
        n_x = r_x;  n_delta = r_delta;  n_e = r_e;  n_t1 = r_t1;  n_e2 = r_e2;
        n_poly = r_poly;  n_tmp = r_tmp;  n_acc = r_acc;
        n_quo = r_quo;  n_rem = r_rem;  n_dcnt = r_dcnt;
        n_mcnt = r_mcnt;  n_prod = r_prod;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.restart) begin
                        n_mean = '0;  n_m2 = '0;  n_m3 = '0;  n_m4 = '0;  n_flag = 1'b0;
                    end
                    if (cnt_eff == CMAX) begin
                        n_n    = CMAX;
                        n_flag = 1'b1;
                    end else begin
                        n_n = cnt_eff + 1'b1;
                    end
                    n_count = n_n;
                    n_x     = $signed({xs[47:0], 16'd0});
                    n_mcnt  = '0;
                end
            end
            ST_DIV: begin
                if (rem_sh >= {1'b0, r_n}) begin
                    n_rem = COUNT_BITS'(rem_sh - {1'b0, r_n});
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh[COUNT_BITS-1:0];
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_dcnt = r_dcnt + 6'd1;
                if (div_last) begin
                    n_e    = e_res.value;
                    n_flag = r_flag | e_res.ovf;
                end
            end
            ST_RUN: begin
                if (op_mul) begin
                    n_prod = ((r_mcnt == 3'd0) ? 128'd0 : r_prod) + pp;
                    n_mcnt = r_mcnt + 3'd1;
                    if (mul_last) begin
                        n_prod = r_prod;
                        n_mcnt = '0;
                        n_flag = r_flag | mul_res.ovf;
                        case (r_pc)
                            OP_P, OP_T1: n_t1   = mul_res.value;
                            OP_E2:       n_e2   = mul_res.value;
                            OP_NN:       n_poly = mul_res.value;
                            default:     n_tmp  = mul_res.value;
                        endcase
                    end
                end else begin
                    n_flag = r_flag | add_res.ovf;
                    case (r_pc)
                        OP_DELTA: begin
                            n_delta = add_res.value;
                            n_quo   = mag64(add_res.value);
                            n_rem   = '0;
                            n_dcnt  = '0;
                        end
                        OP_MEAN: begin
                            if (add_res.value > MEAN_MAX) begin
                                n_mean = MEAN_MAX[47:0];
                                n_flag = 1'b1;
                            end else if (add_res.value < MEAN_MIN) begin
                                n_mean = MEAN_MIN[47:0];
                                n_flag = 1'b1;
                            end else begin
                                n_mean = add_res.value[47:0];
                            end
                        end
                        OP_POLY: n_poly = add_res.value;
                        OP_M4C:  n_m4   = add_res.value[63] ? 64'sd0 : add_res.value;
                        OP_M3B:  n_m3   = add_res.value;
                        OP_M2:   n_m2   = add_res.value[63] ? 64'sd0 : add_res.value;
                        default: n_acc  = add_res.value;
                    endcase
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.count      = (64'(r_count) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                      : 32'(r_count);
                    n_out.mean       = r_mean;
                    n_out.second_sum = r_m2[62:0];
                    n_out.third_sum  = r_m3;
                    n_out.fourth_sum = r_m4[62:0];
                    n_out.saturated  = r_flag;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= OP_DELTA;
            r_count     <= '0;
            r_mean      <= '0;
            r_m2        <= '0;
            r_m3        <= '0;
            r_m4        <= '0;
            r_flag      <= 1'b0;
            r_dcnt      <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_count     <= n_count;
            r_mean      <= n_mean;
            r_m2        <= n_m2;
            r_m3        <= n_m3;
            r_m4        <= n_m4;
            r_flag      <= n_flag;
            r_dcnt      <= n_dcnt;
            r_mcnt      <= n_mcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_x     <= n_x;
        r_delta <= n_delta;
        r_e     <= n_e;
        r_t1    <= n_t1;
        r_e2    <= n_e2;
        r_poly  <= n_poly;
        r_tmp   <= n_tmp;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

endmodule
